### src/hlb_pkg.sv
// ============================================================================
// hlb_pkg
// Shared constants, codes and controller/datapath interface types for the
// health-aware load balancer.
// ============================================================================
package hlb_pkg;

    // Endpoint pool
    localparam int NUM_EP     = 4;
    localparam int EP_W       = 2;
    localparam int CNT_W      = 8;
    localparam int ROT_W      = 32;
    localparam logic [CNT_W-1:0] ACTIVE_MAX = 8'd255;

    // Event kinds
    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Selection policies
    localparam logic STRAT_RR = 1'b0;
    localparam logic STRAT_LC = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_GRANTED     = 2'd0;
    localparam logic [1:0] ST_NO_ENDPOINT = 2'd1;
    localparam logic [1:0] ST_COMPLETED   = 2'd2;

    // Stream widths
    localparam int IN_W  = 8;
    localparam int OUT_W = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input transaction
        logic scan;    // examine one endpoint
        logic commit;  // update state and load the result register
    } hlb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_op;     // op bit of the offered input transaction
        logic scan_last; // scan is at the last endpoint
        logic out_free;  // result register can take a new result
    } hlb_stat_t;

endpackage

### src/health_aware_load_balancer.sv
// ============================================================================
// health_aware_load_balancer
// Picks a healthy endpoint per request and tracks completions.
// ============================================================================
// Usage:
//   s_ channel carries events: request (pick an endpoint) or completion
//   (release a request and report the endpoint's health). m_ channel
//   returns exactly one result transaction per event.
//   The APB port holds the strategy register at address 0 (round robin or
//   least active connections); write it only while the block is idle.
//   Sequence: a request is accepted, the four endpoints are scanned (one
//   endpoint per cycle through the shared compare) and the result is
//   committed to the output register; a completion skips the scan. One
//   event is in work at a time, so no new event is taken until the last
//   one has committed.
//   Reset (aresetn low, synchronous) marks every endpoint healthy, clears
//   all active counts and the rotation counter, and selects round robin.
//   When the receiver stalls, the result waits in the output register; the
//   next event is still accepted and held at its commit until the register
//   is free.
// ============================================================================
module health_aware_load_balancer (
    input  logic        aclk,
    input  logic        aresetn,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] op, [2:1] endpoint_in, [3] success, [7:4] zero
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [3:2] endpoint_out,
                                   // [11:4] active_after, [15:12] healthy_mask
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hlb_pkg::hlb_cmd_t  cmd;
    hlb_pkg::hlb_stat_t stat;
    logic               cfg_we;
    logic               strategy;

    // Register decode: strategy at word 0
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, strategy} : 32'd0;

    hlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hlb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[0]),
        .strategy  (strategy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### src/hlb_ctrl.sv
// ============================================================================
// hlb_ctrl
// Sequencing state machine: accept, scan the endpoints, commit the result.
// ============================================================================
module hlb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hlb_pkg::hlb_stat_t stat,
    output hlb_pkg::hlb_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    // completions need no scan
                    state_next = (stat.in_op == hlb_pkg::OP_COMPLETE) ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/hlb_datapath.sv
// ============================================================================
// hlb_datapath
// Endpoint state, selection scan, rotation counter and result register.
// ============================================================================
module hlb_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hlb_pkg::hlb_cmd_t             cmd,
    output hlb_pkg::hlb_stat_t            stat,
    input  logic [hlb_pkg::IN_W-1:0]      s_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    output logic                          strategy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hlb_pkg::OUT_W-1:0]     m_tdata
);

    // Captured input transaction
    logic                     op_reg;
    logic [hlb_pkg::EP_W-1:0] ep_reg;
    logic                     ok_reg;

    // Endpoint state
    logic [hlb_pkg::NUM_EP-1:0] healthy_reg;
    logic [hlb_pkg::CNT_W-1:0]  cnt_reg [hlb_pkg::NUM_EP];
    logic [hlb_pkg::ROT_W-1:0]  rot_reg;
    logic [1:0]                 rot3_reg;   // rot_reg modulo 3
    logic                       strategy_reg;

    // Scan state
    logic [hlb_pkg::EP_W-1:0]  idx_reg;
    logic [hlb_pkg::EP_W-1:0]  seen_reg;
    logic [hlb_pkg::EP_W-1:0]  pos_reg;
    logic [hlb_pkg::EP_W-1:0]  sel_reg;
    logic [hlb_pkg::CNT_W-1:0] best_reg;
    logic                      found_reg;

    // Result register
    logic                       out_valid_reg;
    logic [hlb_pkg::OUT_W-1:0]  out_data_reg;

    logic [2:0]                healthy_cnt;
    logic [hlb_pkg::EP_W-1:0]  pos_calc;
    logic [hlb_pkg::EP_W-1:0]  rd_idx;
    logic [hlb_pkg::CNT_W-1:0] rd_cnt;
    logic                      rd_healthy;
    logic [hlb_pkg::EP_W-1:0]  upd_idx;
    logic [hlb_pkg::CNT_W-1:0] cnt_new;
    logic [hlb_pkg::NUM_EP-1:0] healthy_new;
    logic [1:0]                res_status;
    logic [hlb_pkg::EP_W-1:0]  res_ep;
    logic [hlb_pkg::CNT_W-1:0] res_act;
    logic                      cnt_we;
    logic                      rot_adv;

    assign strategy = strategy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.in_op     = s_tdata[0];
    assign stat.scan_last = (idx_reg == hlb_pkg::EP_W'(hlb_pkg::NUM_EP - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;

    // Rotation position among healthy endpoints
    assign healthy_cnt = 3'($countones(healthy_reg));
    always_comb begin
        case (healthy_cnt)
            3'd2:    pos_calc = {1'b0, rot_reg[0]};
            3'd3:    pos_calc = rot3_reg;
            3'd4:    pos_calc = rot_reg[1:0];
            default: pos_calc = '0;
        endcase
    end

    // Single read port on the count registers
    assign upd_idx    = (op_reg == hlb_pkg::OP_COMPLETE) ? ep_reg : sel_reg;
    assign rd_idx     = cmd.scan ? idx_reg : upd_idx;
    assign rd_cnt     = cnt_reg[rd_idx];
    assign rd_healthy = healthy_reg[rd_idx];

    // Commit decision
    always_comb begin
        cnt_new     = rd_cnt;
        healthy_new = healthy_reg;
        cnt_we      = 1'b0;
        rot_adv     = 1'b0;
        res_status  = hlb_pkg::ST_COMPLETED;
        res_ep      = ep_reg;
        res_act     = '0;
        if (op_reg == hlb_pkg::OP_COMPLETE) begin
            // decrement floored at zero, health from outcome
            if (rd_cnt != '0) begin
                cnt_new = rd_cnt - 1'b1;
            end
            cnt_we              = 1'b1;
            healthy_new[ep_reg] = ok_reg;
            res_act             = cnt_new;
        end else if (found_reg) begin
            // grant with saturating increment
            if (rd_cnt < hlb_pkg::ACTIVE_MAX) begin
                cnt_new = rd_cnt + 1'b1;
            end
            cnt_we     = 1'b1;
            rot_adv    = (strategy_reg == hlb_pkg::STRAT_RR);
            res_status = hlb_pkg::ST_GRANTED;
            res_ep     = sel_reg;
            res_act    = cnt_new;
        end else begin
            res_status = hlb_pkg::ST_NO_ENDPOINT;
            res_ep     = '0;
        end
    end

    // Input capture and scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tdata[0];
            ep_reg    <= s_tdata[2:1];
            ok_reg    <= s_tdata[3];
            pos_reg   <= pos_calc;
            idx_reg   <= '0;
            seen_reg  <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            sel_reg   <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (strategy_reg == hlb_pkg::STRAT_RR) begin
                if (rd_healthy && !found_reg) begin
                    if (seen_reg == pos_reg) begin
                        found_reg <= 1'b1;
                        sel_reg   <= idx_reg;
                    end
                    seen_reg <= seen_reg + 1'b1;
                end
            end else begin
                if (rd_healthy && (!found_reg || rd_cnt < best_reg)) begin
                    found_reg <= 1'b1;
                    sel_reg   <= idx_reg;
                    best_reg  <= rd_cnt;
                end
            end
        end
    end

    // Endpoint state, rotation counter and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            healthy_reg  <= '1;
            rot_reg      <= '0;
            rot3_reg     <= '0;
            strategy_reg <= hlb_pkg::STRAT_RR;
            for (int i = 0; i < hlb_pkg::NUM_EP; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                strategy_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                healthy_reg <= healthy_new;
                if (cnt_we) begin
                    cnt_reg[upd_idx] <= cnt_new;
                end
                if (rot_adv) begin
                    rot_reg <= rot_reg + 1'b1;
                    // residue restarts when the counter wraps
                    if (rot_reg == '1 || rot3_reg == 2'd2) begin
                        rot3_reg <= '0;
                    end else begin
                        rot3_reg <= rot3_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {healthy_new, res_act, res_ep, res_status};
        end
    end

endmodule
